[sv/tquv_pkg.sv]
package tquv_pkg;

	// Default sizing of the block.
	localparam int unsigned MAX_MAP_WIDTH_DEF     = 4096;
	localparam int unsigned MAX_ATLAS_COLUMNS_DEF = 256;
	localparam int unsigned UV_FRACTION_BITS_DEF  = 16;

	// Tile word layout.
	localparam int unsigned ID_W   = 29;
	localparam int unsigned FLAG_H = 31;
	localparam int unsigned FLAG_V = 30;
	localparam int unsigned FLAG_D = 29;

	localparam int unsigned UV_W    = 24;
	localparam int unsigned PADDR_W = 5;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_MAP_WIDTH       = 3'd0;
	localparam logic [2:0] REG_ORIGIN_X        = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Y        = 3'd2;
	localparam logic [2:0] REG_CELL_W          = 3'd3;
	localparam logic [2:0] REG_CELL_H          = 3'd4;
	localparam logic [2:0] REG_TILESET_COLUMNS = 3'd5;
	localparam logic [2:0] REG_UV_SPAN_U       = 3'd6;
	localparam logic [2:0] REG_UV_SPAN_V       = 3'd7;

	// Corner codes of a quad.
	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_BL = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_TR = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_MUL_U,
		ST_MUL_V,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [31:0] tile_word;
		logic        start_of_map;
	} tile_item_t;

	typedef struct packed {
		logic signed [31:0]   pos_x;
		logic signed [31:0]   pos_y;
		logic signed [UV_W-1:0] tex_u;
		logic signed [UV_W-1:0] tex_v;
		logic [1:0]           corner;
		logic [23:0]          vertex_number;
		logic                 last_of_quad;
	} vertex_item_t;

endpackage

[sv/tquv_divider.sv]
module tquv_divider #(
	parameter int unsigned DIVISOR_W = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [tquv_pkg::ID_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]   divisor,
	output logic                   busy,
	output logic                   done,
	output logic [tquv_pkg::ID_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]   remainder
);
	import tquv_pkg::*;

	localparam int unsigned CNT_W = $clog2(ID_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ID_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ID_W-1:0]      quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] div_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	// One restoring step: bring down the next dividend bit and try to subtract.
	always_comb begin
		trial = {rem_q, quo_q[ID_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	// Control of the bit-serial loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift in where the dividend bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ID_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

`ifndef ASSERT_OFF
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
`endif

endmodule

[sv/tile_quad_uv_generator_unit.sv]
// Flow: a tile with id zero is taken while idle and emits nothing.
// Any other tile is accepted, divided in the bit-serial divider, handed off,
// run through the shared multiplier (u, then v) and emitted as four vertices.
// No new tile is taken until the last vertex of the current quad is loaded.
// Reset (arst_n low) clears the cursor to the origin, the vertex count to 0
// and the registers to their defaults; no vertex is pending after reset.
module tile_quad_uv_generator_unit #(
	parameter int unsigned MAX_MAP_WIDTH     = tquv_pkg::MAX_MAP_WIDTH_DEF,
	parameter int unsigned MAX_ATLAS_COLUMNS = tquv_pkg::MAX_ATLAS_COLUMNS_DEF,
	parameter int unsigned UV_FRACTION_BITS  = tquv_pkg::UV_FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tile_valid,
	output logic                          tile_stall,
	input  tquv_pkg::tile_item_t          tile,
	output logic                          vertex_valid,
	input  logic                          vertex_stall,
	output tquv_pkg::vertex_item_t        vertex,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tquv_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tquv_pkg::*;

	localparam int unsigned CNT_W = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
	localparam int unsigned DIV_W = $clog2(MAX_ATLAS_COLUMNS + 1);
	localparam logic [UV_W-1:0] UV_ONE = UV_W'(64'd1 << UV_FRACTION_BITS);

	// Configuration registers.
	logic [12:0]        map_width_q;
	logic signed [20:0] origin_x_q;
	logic signed [20:0] origin_y_q;
	logic [10:0]        cell_w_q;
	logic [10:0]        cell_h_q;
	logic [8:0]         tileset_columns_q;
	logic [16:0]        uv_span_u_q;
	logic [16:0]        uv_span_v_q;

	logic       cfg_write;
	logic [2:0] cfg_index;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_index = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q       <= 13'd1;
			origin_x_q        <= '0;
			origin_y_q        <= '0;
			cell_w_q          <= 11'd16;
			cell_h_q          <= 11'd16;
			tileset_columns_q <= 9'd1;
			uv_span_u_q       <= 17'd65536;
			uv_span_v_q       <= 17'd65536;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:       map_width_q       <= pwdata[12:0];
				REG_ORIGIN_X:        origin_x_q        <= pwdata[20:0];
				REG_ORIGIN_Y:        origin_y_q        <= pwdata[20:0];
				REG_CELL_W:          cell_w_q          <= pwdata[10:0];
				REG_CELL_H:          cell_h_q          <= pwdata[10:0];
				REG_TILESET_COLUMNS: tileset_columns_q <= pwdata[8:0];
				REG_UV_SPAN_U:       uv_span_u_q       <= pwdata[16:0];
				REG_UV_SPAN_V:       uv_span_v_q       <= pwdata[16:0];
				default:             ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (cfg_index)
			REG_MAP_WIDTH:       prdata = 32'(map_width_q);
			REG_ORIGIN_X:        prdata = 32'(unsigned'(origin_x_q));
			REG_ORIGIN_Y:        prdata = 32'(unsigned'(origin_y_q));
			REG_CELL_W:          prdata = 32'(cell_w_q);
			REG_CELL_H:          prdata = 32'(cell_h_q);
			REG_TILESET_COLUMNS: prdata = 32'(tileset_columns_q);
			REG_UV_SPAN_U:       prdata = 32'(uv_span_u_q);
			REG_UV_SPAN_V:       prdata = 32'(uv_span_v_q);
			default:             prdata = '0;
		endcase
	end

	// Effective map width and atlas column count, clamped to their limits.
	logic [31:0]      map_w_eff;
	logic [DIV_W-1:0] cols_eff;

	always_comb begin
		if (map_width_q == '0) begin
			map_w_eff = 32'd1;
		end else if (32'(map_width_q) > 32'(MAX_MAP_WIDTH)) begin
			map_w_eff = 32'(MAX_MAP_WIDTH);
		end else begin
			map_w_eff = 32'(map_width_q);
		end
		if (tileset_columns_q == '0) begin
			cols_eff = DIV_W'(1);
		end else if (32'(tileset_columns_q) > 32'(MAX_ATLAS_COLUMNS)) begin
			cols_eff = DIV_W'(MAX_ATLAS_COLUMNS);
		end else begin
			cols_eff = DIV_W'(tileset_columns_q);
		end
	end

	// Sequencer state and item registers.
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  col_q;
	logic [31:0]       left_q;
	logic [31:0]       top_q;
	logic [23:0]       vcount_q;
	logic [1:0]        k_q;
	logic              flip_h_q, flip_v_q, flip_d_q;
	logic [UV_W-1:0]   u0_q, v0_q;
	logic              vout_q;
	vertex_item_t      vertex_q;

	logic              accept;
	logic              id_zero;
	logic              load_ok;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic              emit_load;
	logic              emit_last;
	logic [ID_W-1:0]   div_quo;
	logic [DIV_W-1:0]  div_rem;

	assign accept    = tile_valid && !tile_stall;
	assign id_zero   = (tile.tile_word[ID_W-1:0] == '0);
	assign load_ok   = !vout_q || !vertex_stall;
	assign tile_stall = (state_q != ST_IDLE);

	// Next state and sequencer strobes.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !id_zero) begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_MUL_U;
				end
			end
			ST_MUL_U: begin
				state_d = ST_MUL_V;
			end
			ST_MUL_V: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_ok) begin
					emit_load = 1'b1;
					if (k_q == CORNER_TR) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign emit_last = emit_load && (k_q == CORNER_TR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Serial division of id-1 by the atlas column count.
	tquv_divider #(
		.DIVISOR_W(DIV_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tile.tile_word[ID_W-1:0] - 1'b1),
		.divisor  (cols_eff),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Shared multiplier: atlas column by tile u size, then atlas row by tile v size.
	logic [UV_W-1:0] mul_a;
	logic [16:0]     mul_b;
	logic [40:0]     mul_p;

	always_comb begin
		if (state_q == ST_MUL_U) begin
			mul_a = UV_W'(div_rem);
			mul_b = uv_span_u_q;
		end else begin
			mul_a = div_quo[UV_W-1:0];
			mul_b = uv_span_v_q;
		end
		mul_p = 41'(mul_a) * 41'(mul_b);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flip_h_q <= tile.tile_word[FLAG_H];
			flip_v_q <= tile.tile_word[FLAG_V];
			flip_d_q <= tile.tile_word[FLAG_D];
		end
		if (state_q == ST_MUL_U) begin
			u0_q <= mul_p[UV_W-1:0];
		end
		if (state_q == ST_MUL_V) begin
			v0_q <= UV_ONE - mul_p[UV_W-1:0];
		end
	end

	// Grid cursor: start of map restarts it, and every tile advances it.
	logic [31:0]      org_x, org_y;
	logic [CNT_W-1:0] cur_col, src_col, adv_col;
	logic [31:0]      cur_left, cur_top, src_left, src_top, adv_left, adv_top;
	logic [CNT_W:0]   next_col;
	logic             wrap;

	always_comb begin
		org_x    = 32'(origin_x_q);
		org_y    = 32'(origin_y_q);
		cur_col  = tile.start_of_map ? '0 : col_q;
		cur_left = tile.start_of_map ? org_x : left_q;
		cur_top  = tile.start_of_map ? org_y : top_q;
		src_col  = (state_q == ST_IDLE) ? cur_col : col_q;
		src_left = (state_q == ST_IDLE) ? cur_left : left_q;
		src_top  = (state_q == ST_IDLE) ? cur_top : top_q;
		next_col = {1'b0, src_col} + 1'b1;
		wrap     = (32'(next_col) >= map_w_eff);
		adv_col  = wrap ? '0 : next_col[CNT_W-1:0];
		adv_left = wrap ? org_x : src_left + 32'(cell_w_q);
		adv_top  = wrap ? src_top - 32'(cell_h_q) : src_top;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			left_q <= '0;
			top_q  <= '0;
		end else if (accept && id_zero) begin
			col_q  <= adv_col;
			left_q <= adv_left;
			top_q  <= adv_top;
		end else if (accept) begin
			col_q  <= cur_col;
			left_q <= cur_left;
			top_q  <= cur_top;
		end else if (emit_last) begin
			col_q  <= adv_col;
			left_q <= adv_left;
			top_q  <= adv_top;
		end
	end

	// Corner values of the current quad.
	logic [UV_W-1:0] u_lo, u_hi, v_lo;
	logic [UV_W-1:0] u_a, u_b, v_a, v_b, u_k, v_k;
	logic [31:0]     x_r, y_b, x_k, y_k;

	always_comb begin
		u_lo = u0_q;
		u_hi = u0_q + UV_W'(uv_span_u_q);
		v_lo = v0_q - UV_W'(uv_span_v_q);
		u_a  = flip_h_q ? u_hi : u_lo;
		u_b  = flip_h_q ? u_lo : u_hi;
		v_a  = flip_v_q ? v_lo : v0_q;
		v_b  = flip_v_q ? v0_q : v_lo;
		x_r  = left_q + 32'(cell_w_q);
		y_b  = top_q - 32'(cell_h_q);
		case (k_q)
			CORNER_TL: begin
				x_k = left_q;
				y_k = top_q;
				u_k = flip_d_q ? u_b : u_a;
				v_k = v_a;
			end
			CORNER_BL: begin
				x_k = left_q;
				y_k = y_b;
				u_k = u_a;
				v_k = flip_d_q ? v_a : v_b;
			end
			CORNER_BR: begin
				x_k = x_r;
				y_k = y_b;
				u_k = flip_d_q ? u_a : u_b;
				v_k = v_b;
			end
			default: begin
				x_k = x_r;
				y_k = top_q;
				u_k = u_b;
				v_k = flip_d_q ? v_b : v_a;
			end
		endcase
	end

	// Corner index and running vertex count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= CORNER_TL;
			vcount_q <= '0;
		end else begin
			if (accept) begin
				k_q <= CORNER_TL;
			end else if (emit_load) begin
				k_q <= k_q + 1'b1;
			end
			if (emit_load) begin
				vcount_q <= vcount_q + 1'b1;
			end
		end
	end

	// Output register: holds one item until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_q <= 1'b0;
		end else if (emit_load) begin
			vout_q <= 1'b1;
		end else if (!vertex_stall) begin
			vout_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			vertex_q.pos_x         <= x_k;
			vertex_q.pos_y         <= y_k;
			vertex_q.tex_u         <= u_k;
			vertex_q.tex_v         <= v_k;
			vertex_q.corner        <= k_q;
			vertex_q.vertex_number <= vcount_q;
			vertex_q.last_of_quad  <= (k_q == CORNER_TR);
		end
	end

	assign vertex_valid = vout_q;
	assign vertex       = vertex_q;

`ifndef ASSERT_OFF
	a_last_on_tr: assert property (@(posedge clk) disable iff (!arst_n)
		vout_q |-> (vertex_q.last_of_quad == (vertex_q.corner == CORNER_TR)))
		else $error("last_of_quad does not match the top-right corner");
	a_zero_id_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && id_zero) |=> (state_q == ST_IDLE))
		else $error("tile with id zero started work");
	a_mul_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_V) |=> (state_q == ST_EMIT && k_q == CORNER_TL))
		else $error("emission did not start at the top-left corner");
	a_div_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIVIDE))
		else $error("divider running outside the divide state");
`endif

endmodule

[test/tquv_scoreboard_pkg.sv]
`timescale 1ns / 100ps
package tquv_scoreboard_pkg;

	import tquv_pkg::*;

	// Predicts the vertices of every accepted tile and checks the block's output against them.
	class vertex_scoreboard;

		// Register copies at their implemented widths.
		logic [12:0]        map_width;
		logic signed [20:0] origin_x;
		logic signed [20:0] origin_y;
		logic [10:0]        cell_w;
		logic [10:0]        cell_h;
		logic [8:0]         tileset_columns;
		logic [16:0]        uv_span_u;
		logic [16:0]        uv_span_v;

		// Grid cursor and running vertex count.
		logic [11:0] column;
		logic [31:0] left_edge;
		logic [31:0] top_edge;
		logic [23:0] vertex_total;

		vertex_item_t expected_vertices[$];
		int errors;
		int tiles_seen;
		int vertices_checked;

		function new();
			errors = 0;
			tiles_seen = 0;
			vertices_checked = 0;
			clear();
		endfunction

		// Register defaults and the cursor at the origin, as after reset.
		function void clear();
			map_width = 13'd1;
			origin_x = '0;
			origin_y = '0;
			cell_w = 11'd16;
			cell_h = 11'd16;
			tileset_columns = 9'd1;
			uv_span_u = 17'd65536;
			uv_span_v = 17'd65536;
			column = '0;
			left_edge = '0;
			top_edge = '0;
			vertex_total = '0;
			expected_vertices.delete();
		endfunction

		function void write_register(logic [2:0] index, logic [31:0] data);
			case (index)
				REG_MAP_WIDTH:       map_width = data[12:0];
				REG_ORIGIN_X:        origin_x = data[20:0];
				REG_ORIGIN_Y:        origin_y = data[20:0];
				REG_CELL_W:          cell_w = data[10:0];
				REG_CELL_H:          cell_h = data[10:0];
				REG_TILESET_COLUMNS: tileset_columns = data[8:0];
				REG_UV_SPAN_U:       uv_span_u = data[16:0];
				REG_UV_SPAN_V:       uv_span_v = data[16:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_vertices.size();
		endfunction

		// Works out the quad of one accepted tile and moves the cursor on.
		function void note_tile(tile_item_t item);
			logic [ID_W-1:0] id;
			logic            flip_h;
			logic            flip_v;
			logic            flip_d;
			int unsigned     row_len;
			int unsigned     atlas_cols;
			logic [63:0]     tile_index;
			logic [63:0]     atlas_col;
			logic [63:0]     atlas_row;
			logic [63:0]     u0;
			logic [63:0]     v0;
			logic [63:0]     u_a;
			logic [63:0]     u_b;
			logic [63:0]     v_a;
			logic [63:0]     v_b;
			logic [63:0]     corner_u[4];
			logic [63:0]     corner_v[4];
			logic [31:0]     corner_x[4];
			logic [31:0]     corner_y[4];
			logic [1:0]      corner_code[4];
			vertex_item_t    vert;

			tiles_seen++;
			corner_code = '{CORNER_TL, CORNER_BL, CORNER_BR, CORNER_TR};

			// A start of map puts the cursor back at the current origin.
			if (item.start_of_map) begin
				column = '0;
				left_edge = {{11{origin_x[20]}}, origin_x};
				top_edge = {{11{origin_y[20]}}, origin_y};
			end

			id = item.tile_word[ID_W-1:0];
			flip_h = item.tile_word[FLAG_H];
			flip_v = item.tile_word[FLAG_V];
			flip_d = item.tile_word[FLAG_D];

			// Empty tiles emit nothing but still take a grid cell.
			if (id != '0) begin
				atlas_cols = (tileset_columns == '0) ? 1 : int'(tileset_columns);
				if (atlas_cols > MAX_ATLAS_COLUMNS_DEF) begin
					atlas_cols = MAX_ATLAS_COLUMNS_DEF;
				end
				tile_index = 64'(id) - 64'd1;
				atlas_col = tile_index % 64'(atlas_cols);
				atlas_row = tile_index / 64'(atlas_cols);

				// The atlas v axis grows upward from 1.0 at the top row.
				u0 = atlas_col * 64'(uv_span_u);
				v0 = (64'd1 << UV_FRACTION_BITS_DEF) - atlas_row * 64'(uv_span_v);
				u_a = flip_h ? u0 + 64'(uv_span_u) : u0;
				u_b = flip_h ? u0 : u0 + 64'(uv_span_u);
				v_a = flip_v ? v0 - 64'(uv_span_v) : v0;
				v_b = flip_v ? v0 : v0 - 64'(uv_span_v);

				if (!flip_d) begin
					corner_u = '{u_a, u_a, u_b, u_b};
					corner_v = '{v_a, v_b, v_b, v_a};
				end else begin
					corner_u = '{u_b, u_a, u_a, u_b};
					corner_v = '{v_a, v_a, v_b, v_b};
				end
				corner_x = '{left_edge, left_edge, left_edge + 32'(cell_w),
					left_edge + 32'(cell_w)};
				corner_y = '{top_edge, top_edge - 32'(cell_h), top_edge - 32'(cell_h),
					top_edge};

				for (int k = 0; k < 4; k++) begin
					vert.pos_x = corner_x[k];
					vert.pos_y = corner_y[k];
					vert.tex_u = corner_u[k][UV_W-1:0];
					vert.tex_v = corner_v[k][UV_W-1:0];
					vert.corner = corner_code[k];
					vert.vertex_number = vertex_total;
					vert.last_of_quad = (k == 3);
					expected_vertices.insert(expected_vertices.size(), vert);
					vertex_total = vertex_total + 24'd1;
				end
			end

			// Step one cell right, wrapping to the next row at the clamped map width.
			row_len = (map_width == '0) ? 1 : int'(map_width);
			if (row_len > MAX_MAP_WIDTH_DEF) begin
				row_len = MAX_MAP_WIDTH_DEF;
			end
			left_edge = left_edge + 32'(cell_w);
			if (int'(column) + 1 >= row_len) begin
				column = '0;
				left_edge = {{11{origin_x[20]}}, origin_x};
				top_edge = top_edge - 32'(cell_h);
			end else begin
				column = column + 12'd1;
			end
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Compares one vertex that left the block with the oldest prediction.
		function void check_vertex(vertex_item_t got);
			vertex_item_t want;

			vertices_checked++;
			if (expected_vertices.size() == 0) begin
				$error("vertex %0d arrived while none was expected", got.vertex_number);
				errors++;
				return;
			end
			want = expected_vertices.pop_front();
			compare_field("pos_x", want.pos_x, got.pos_x);
			compare_field("pos_y", want.pos_y, got.pos_y);
			compare_field("tex_u", want.tex_u, got.tex_u);
			compare_field("tex_v", want.tex_v, got.tex_v);
			compare_field("corner", want.corner, got.corner);
			compare_field("vertex_number", want.vertex_number, got.vertex_number);
			compare_field("last_of_quad", want.last_of_quad, got.last_of_quad);
		endfunction

	endclass

endpackage

[test/tb_tile_quad_uv_generator_unit.sv]
`timescale 1ns / 100ps
module tb_tile_quad_uv_generator_unit;

	import tquv_pkg::*;
	import tquv_scoreboard_pkg::*;

	// Settling time that covers the tail of a batch.
	localparam int TILE_LATENCY = 48;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                tile_valid = 1'b0;
	logic                tile_stall;
	tile_item_t          tile = '0;
	logic                vertex_valid;
	logic                vertex_stall = 1'b0;
	vertex_item_t        vertex;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	// Idling switch for the final stretch, and a request for a long receiver hold.
	bit quiet = 1'b0;
	int hold_request = 0;

	vertex_scoreboard sb = new();

	tile_quad_uv_generator_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.tile_valid   (tile_valid),
		.tile_stall   (tile_stall),
		.tile         (tile),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	// Every vertex the block hands over is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && vertex_valid && !vertex_stall) begin
			sb.check_vertex(vertex);
		end
	end

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin : vertex_sink
		int burst;

		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				burst = hold_request;
				hold_request = 0;
				vertex_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				vertex_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < 20) begin
				burst = $urandom_range(1, 19);
				vertex_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				vertex_stall <= 1'b0;
			end else begin
				vertex_stall <= 1'b0;
			end
		end
	end

	function automatic int sender_gap();
		if (quiet || $urandom_range(0, 99) >= 25) begin
			return 0;
		end
		return $urandom_range(1, 19);
	endfunction

	function automatic tile_item_t make_tile(logic [2:0] flags, logic [ID_W-1:0] id,
		logic restart);
		return {flags, id, restart};
	endfunction

	// Mostly small ids that land in the atlas, with empty, huge and wide-range ids mixed in.
	function automatic tile_item_t random_tile();
		int               pick;
		logic [ID_W-1:0]  id;

		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			id = '0;
		end else if (pick < 65) begin
			id = ID_W'($urandom_range(1, 64));
		end else if (pick < 85) begin
			id = ID_W'($urandom);
		end else begin
			id = {ID_W{1'b1}} - ID_W'($urandom_range(0, 15));
		end
		return make_tile(3'($urandom), id, $urandom_range(0, 99) < 6);
	endfunction

	// Offers one tile and waits for it to be taken. A gap or a drain drops valid first.
	task automatic send_tile(input tile_item_t item, input int gap, input bit drain_first);
		@(negedge clk);
		if (gap > 0 || drain_first) begin
			tile_valid <= 1'b0;
			repeat ((gap > 0) ? gap : 1) @(negedge clk);
			while (drain_first && sb.pending() != 0) @(negedge clk);
		end
		tile_valid <= 1'b1;
		tile <= item;
		@(posedge clk);
		while (tile_stall) @(posedge clk);
		sb.note_tile(item);
	endtask

	// Stops offering, waits for every predicted vertex, then lets the block settle.
	task automatic finish_batch();
		@(negedge clk);
		tile_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TILE_LATENCY) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] index, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_register(index, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_settings(input logic [31:0] map_w, input logic [31:0] org_x,
		input logic [31:0] org_y, input logic [31:0] tile_w, input logic [31:0] tile_h,
		input logic [31:0] atlas_cols, input logic [31:0] uv_w, input logic [31:0] uv_h);
		write_register(REG_MAP_WIDTH, map_w);
		write_register(REG_ORIGIN_X, org_x);
		write_register(REG_ORIGIN_Y, org_y);
		write_register(REG_CELL_W, tile_w);
		write_register(REG_CELL_H, tile_h);
		write_register(REG_TILESET_COLUMNS, atlas_cols);
		write_register(REG_UV_SPAN_U, uv_w);
		write_register(REG_UV_SPAN_V, uv_h);
	endtask

	task automatic run_random_tiles(input int count, input int drain_at);
		for (int i = 0; i < count; i++) begin
			send_tile(random_tile(), sender_gap(), i == drain_at);
		end
		finish_batch();
	endtask

	initial begin : stimulus
		tile_item_t directed[$];

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Register defaults straight out of reset.
		send_tile(make_tile(3'b000, 1, 1'b0), 0, 1'b0);
		send_tile(make_tile(3'b101, 2, 1'b0), sender_gap(), 1'b0);
		finish_batch();

		// Every flip combination, empty tiles, the largest id, restarts and row wraps.
		apply_settings(3, -5, 100, 16, 8, 4, 16384, 8192);
		directed = '{
			make_tile(3'b000, 1, 1'b1), make_tile(3'b001, 2, 1'b0),
			make_tile(3'b100, 3, 1'b0), make_tile(3'b010, 4, 1'b0),
			make_tile(3'b110, 5, 1'b0), make_tile(3'b111, 6, 1'b0),
			make_tile(3'b011, 7, 1'b0), make_tile(3'b101, 8, 1'b0),
			make_tile(3'b000, 0, 1'b0), make_tile(3'b111, 0, 1'b0),
			make_tile(3'b111, {ID_W{1'b1}}, 1'b0), make_tile(3'b000, {ID_W{1'b1}}, 1'b0),
			make_tile(3'b000, 9, 1'b1), make_tile(3'b010, 4, 1'b0),
			make_tile(3'b100, 5, 1'b0)
		};
		foreach (directed[i]) begin
			send_tile(directed[i], sender_gap(), 1'b0);
		end
		finish_batch();

		// A new origin leaves the cursor alone until a row wrap or a restart.
		write_register(REG_ORIGIN_X, 300);
		write_register(REG_ORIGIN_Y, -40);
		send_tile(make_tile(3'b000, 1, 1'b0), 0, 1'b0);
		send_tile(make_tile(3'b000, 2, 1'b0), 0, 1'b0);
		send_tile(make_tile(3'b000, 3, 1'b0), 0, 1'b0);
		send_tile(make_tile(3'b000, 1, 1'b1), 0, 1'b0);
		finish_batch();

		// Ordinary map while the receiver holds off long enough to back the block up.
		apply_settings(5, 0, 0, 16, 16, 8, 8192, 8192);
		hold_request = 400;
		run_random_tiles(45, -1);

		// Lowest settings: zero width and columns act as one, zero UV sizes.
		apply_settings(0, -1048576, -1048576, 1, 1, 0, 0, 0);
		run_random_tiles(40, 20);

		// Highest legal settings.
		apply_settings(4096, 1048575, 1048575, 1024, 1024, 256, 65536, 65536);
		run_random_tiles(40, -1);

		// Values past the limits, with high bits beyond each register's width.
		apply_settings(8191, 123, -77, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 511, 131071,
			32'hFFFF_FFFF);
		run_random_tiles(40, -1);

		// Random legal settings, run flat out with no idling on either side.
		quiet = 1'b1;
		apply_settings($urandom_range(1, 12), $urandom_range(0, 2097151),
			$urandom_range(0, 2097151), $urandom_range(1, 1024), $urandom_range(1, 1024),
			$urandom_range(1, 256), $urandom_range(0, 65536), $urandom_range(0, 65536));
		run_random_tiles(45, -1);

		$display("Checked %0d vertices from %0d tiles under default, directed and random settings.",
			sb.vertices_checked, sb.tiles_seen);
		$display("Settings ranged from zero and past-limit sizes to both origin extremes.");
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
